// ----- design/vcsp_pkg.sv -----
// Package: vertex record types and float product types for the color scaler.
package vcsp_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned MantW = 24;
	localparam int unsigned ProdW = 2 * MantW;

	typedef struct packed {
		logic [WordW-1:0] pos_x;
		logic [WordW-1:0] pos_y;
		logic [WordW-1:0] pos_z;
		logic [WordW-1:0] color_in;
		logic [WordW-1:0] tex_u;
		logic [WordW-1:0] tex_v;
		logic [WordW-1:0] brightness;
		logic [WordW-1:0] multiplier;
	} vtx_in_t;

	typedef struct packed {
		logic [WordW-1:0] out_pos_x;
		logic [WordW-1:0] out_pos_y;
		logic [WordW-1:0] out_pos_z;
		logic [WordW-1:0] color_out;
		logic [WordW-1:0] out_tex_u;
		logic [WordW-1:0] out_tex_v;
		logic [WordW-1:0] out_light;
	} vtx_out_t;

	// Product class after the multiply stage.
	typedef enum logic [1:0] {
		PC_ZERO = 2'd0,
		PC_NUM  = 2'd1,
		PC_SAT  = 2'd2,
		PC_NAN  = 2'd3
	} pclass_t;

	typedef struct packed {
		pclass_t          pc;
		logic             sign;
		logic [9:0]       exp;   // unbiased exponent of mantissa bit 23, signed
		logic [ProdW-1:0] prod;
	} chan_mul_t;

endpackage

// ----- design/vcsp_if.sv -----
// Interfaces: valid/ready channels for input and result vertices.
interface vcsp_in_if;
	logic                valid;
	logic                ready;
	vcsp_pkg::vtx_in_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface vcsp_out_if;
	logic                valid;
	logic                ready;
	vcsp_pkg::vtx_out_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- design/vertex_color_scale_pack.sv -----
// Top level: three-stage pipeline that scales the color bytes of a vertex.
// One vertex enters per cycle while the output is not stalled, and its result
// passes through the stages in order (stage 1 multiplies byte by mantissa,
// stage 2 rounds and converts, stage 3 packs the color word); throughput is
// one vertex per cycle, set by the fully pipelined multiply and convert per
// color channel, and a stall at the output holds all stages without loss.
module vertex_color_scale_pack (
	input  logic        clk,
	input  logic        arst_n,
	vcsp_in_if.sink     in_ch,
	vcsp_out_if.source  out_ch
);
	import vcsp_pkg::*;

	logic      v_s1, v_s2, v_s3;
	vtx_in_t   d_s1, d_s2;
	chan_mul_t mul_c[3];
	chan_mul_t mul_s1[3];
	logic [WordW-1:0] cvt_c[3];
	logic [WordW-1:0] w_s2[3];
	vtx_out_t  o_s3;
	logic      adv;

	assign adv = !v_s3 || out_ch.ready;
	assign in_ch.ready = adv;

	for (genvar k = 0; k < 3; k++) begin : g_ch
		vcsp_chan_mul u_mul (
			.ch  (in_ch.data.color_in[8*k +: 8]),
			.m   (in_ch.data.multiplier),
			.res (mul_c[k])
		);
		vcsp_chan_cvt u_cvt (
			.mr   (mul_s1[k]),
			.word (cvt_c[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1   <= in_ch.data;
			mul_s1 <= mul_c;
			d_s2   <= d_s1;
			w_s2   <= cvt_c;
			o_s3.out_pos_x <= d_s2.pos_x;
			o_s3.out_pos_y <= d_s2.pos_y;
			o_s3.out_pos_z <= d_s2.pos_z;
			o_s3.color_out <= (d_s2.color_in & 32'hFF00_0000) | (w_s2[2] << 16)
				| (w_s2[1] << 8) | w_s2[0];
			o_s3.out_tex_u <= d_s2.tex_u;
			o_s3.out_tex_v <= d_s2.tex_v;
			o_s3.out_light <= d_s2.brightness;
		end
	end

	assign out_ch.valid = v_s3;
	assign out_ch.data  = o_s3;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !out_ch.ready |=> v_s3 && $stable(o_s3))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s3 |-> in_ch.ready)
		else $error("empty output blocked input");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> v_s1)
		else $error("accepted beat lost at stage 1");
endmodule

// ----- design/vcsp_chan_mul.sv -----
// Channel multiply: byte times float mantissa, exponent and class.
module vcsp_chan_mul (
	input  logic [7:0]                ch,
	input  logic [vcsp_pkg::WordW-1:0] m,
	output vcsp_pkg::chan_mul_t       res
);
	import vcsp_pkg::*;

	logic [7:0]       me;
	logic [22:0]      mf;
	logic [MantW-1:0] mm;
	logic [9:0]       e;

	always_comb begin
		me = m[30:23];
		mf = m[22:0];
		mm = (me == 8'd0) ? {1'b0, mf} : {1'b1, mf};
		// value = ch * mm * 2^(e-23); e is exponent of mantissa bit 23
		e = (me == 8'd0) ? 10'(-126) : 10'({2'b00, me} - 10'd127);
		res.sign = m[31];
		res.prod = {{(ProdW-MantW){1'b0}}, mm} * {{(ProdW-8){1'b0}}, ch};
		res.exp = e;
		if (me == 8'hFF && mf != 23'd0) begin
			res.pc = PC_NAN;
		end else if (me == 8'hFF) begin
			res.pc = (ch == 8'd0) ? PC_NAN : PC_SAT;
		end else if (ch == 8'd0 || mm == '0) begin
			res.pc = PC_ZERO;
		end else begin
			res.pc = PC_NUM;
		end
	end
endmodule

// ----- design/vcsp_chan_cvt.sv -----
// Channel convert: round product to single, truncate to saturated int32.
module vcsp_chan_cvt (
	input  vcsp_pkg::chan_mul_t        mr,
	output logic [vcsp_pkg::WordW-1:0] word
);
	import vcsp_pkg::*;

	logic [5:0]       lz;
	logic [ProdW-1:0] nrm;
	logic [24:0]      mant;
	logic             g, st, up;
	logic signed [11:0] pe;   // exponent of rounded msb
	logic [23:0]      rm;
	logic [31:0]      mag;
	logic signed [11:0] sh;

	always_comb begin
		lz = '0;
		for (int i = 0; i < ProdW; i++) begin
			if (mr.prod[i]) lz = 6'(ProdW - 1 - i);
		end
		nrm = mr.prod << lz;
		// product has msb at bit 47-lz; weight of bit 23 of mm is 2^exp
		pe = 12'(signed'(mr.exp)) + 12'sd24 - 12'(signed'({1'b0, lz}));
		// subnormal product results are below 1, truncate to zero anyway
		g  = nrm[ProdW-25];
		st = |nrm[ProdW-26:0];
		mant = {1'b0, nrm[ProdW-1:ProdW-24]};
		up = g & (st | mant[0]);
		mant = mant + 25'(up);
		if (mant[24]) begin
			rm = mant[24:1];
			pe = pe + 12'sd1;
		end else begin
			rm = mant[23:0];
		end
		mag = '0;
		sh = pe - 12'sd23;
		if (pe < 12'sd0) mag = '0;
		else if (sh >= 12'sd0) mag = {8'd0, rm} << sh[2:0];
		else mag = 32'({8'd0, rm} >> (-sh));
		word = '0;
		case (mr.pc)
			PC_NAN:  word = '0;
			PC_ZERO: word = '0;
			PC_SAT:  word = mr.sign ? 32'h8000_0000 : 32'h7FFF_FFFF;
			PC_NUM: begin
				if (pe >= 12'sd31) word = mr.sign ? 32'h8000_0000 : 32'h7FFF_FFFF;
				else word = mr.sign ? (~mag + 32'd1) : mag;
			end
			default: word = '0;
		endcase
	end
endmodule
